### rtl/assert_macros.svh
// Assertion macros shared by the motion detector RTL.
// No dependencies; included by modules that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every rising clock edge outside reset.
`define AMD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// Implication checked outside reset.
`define AMD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("implication failed");

`endif

### rtl/amd_pkg.sv
// Shared constants and types for the accelerometer motion detector.
// No dependencies; used by every module of the block.
package amd_pkg;

  localparam int WindowLen = 10;
  localparam int SlotW = $clog2(WindowLen);
  localparam int SumW = 16 + $clog2(WindowLen);
  localparam int ValW = 16;
  localparam int WholeW = 10;
  localparam int FracW = 21;
  localparam int ThrW = 16;
  localparam logic [ThrW-1:0] ThresholdReset = 16'd250;

  // Truncating division of the millionths part by 10000 as a reciprocal product.
  localparam int FracShift = 37;
  localparam int FracRecipW = 24;
  localparam logic [FracRecipW-1:0] FracRecip = 24'd13743896;
  localparam int FracQuotW = 8;

  // Truncating division of the window sum by the window length.
  localparam int MeanShift = 28;
  localparam longint MeanRecipL = ((64'd1 << MeanShift) + WindowLen - 1) / WindowLen;
  localparam logic [MeanShift-1:0] MeanRecip = MeanShift'(MeanRecipL);
  localparam logic [SlotW-1:0] SlotLast = SlotW'(WindowLen - 1);

  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
    logic en4;
    logic upd;
    logic [SlotW-1:0] slot;
  } pipe_ctl_t;

endpackage

### rtl/amd_ctrl.sv
// Pipeline control: stage valid bits, per-stage enables and the ring write slot.
// Depends on amd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module amd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 out_ready_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  output amd_pkg::pipe_ctl_t   ctl_o
);

  logic [3:0] vld_q, vld_d;
  logic [amd_pkg::SlotW-1:0] slot_q, slot_d;
  logic en1, en2, en3, en4, upd;

  always_comb begin
    en4 = !vld_q[3] || out_ready_i;
    en3 = !vld_q[2] || en4;
    en2 = !vld_q[1] || en3;
    en1 = !vld_q[0] || en2;
    upd = vld_q[0] && en2;
    vld_d = vld_q;
    if (en1) vld_d[0] = in_valid_i;
    if (en2) vld_d[1] = vld_q[0];
    if (en3) vld_d[2] = vld_q[1];
    if (en4) vld_d[3] = vld_q[2];
    slot_d = slot_q;
    if (upd) begin
      slot_d = (slot_q == amd_pkg::SlotLast) ? '0 : slot_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      slot_q <= '0;
    end else begin
      vld_q  <= vld_d;
      slot_q <= slot_d;
    end
  end

  assign in_ready_o  = en1;
  assign out_valid_o = vld_q[3];
  assign ctl_o = '{en1: en1, en2: en2, en3: en3, en4: en4, upd: upd, slot: slot_q};

  `AMD_ASSERT(slot_in_window, clk_i, rst_ni, slot_q <= amd_pkg::SlotLast)
  `AMD_ASSERT_IMP(slot_advances, clk_i, rst_ni, upd && slot_q != amd_pkg::SlotLast, ##1 slot_q == $past(slot_q) + 1'b1)
  `AMD_ASSERT_IMP(result_held, clk_i, rst_ni, vld_q[3] && !out_ready_i, ##1 vld_q[3])

endmodule

### rtl/amd_lane.sv
// One axis lane: value conversion, ring history with running sum, mean and threshold test.
// Depends on amd_pkg and assert_macros.svh; driven by amd_ctrl through pipe_ctl_t.
`include "assert_macros.svh"

module amd_lane (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  amd_pkg::pipe_ctl_t                ctl_i,
  input  logic signed [amd_pkg::WholeW-1:0] whole_i,
  input  logic signed [amd_pkg::FracW-1:0]  frac_i,
  input  logic [amd_pkg::ThrW-1:0]          thresh_i,
  output logic signed [amd_pkg::ValW-1:0]   value_o,
  output logic                              motion_o
);

  localparam int FracProdW = amd_pkg::FracW + amd_pkg::FracRecipW;
  localparam int MeanProdW = amd_pkg::SumW + amd_pkg::MeanShift;

  logic [amd_pkg::FracW-1:0] frac_mag;
  logic [FracProdW-1:0] frac_prod;
  logic frac_neg_q;
  logic [amd_pkg::FracQuotW-1:0] quot_q;
  logic signed [16:0] wh_q;

  logic signed [16:0] quot_s, val_sum;
  logic signed [amd_pkg::ValW-1:0] value;
  logic signed [amd_pkg::ValW-1:0] hist_q [amd_pkg::WindowLen];
  logic signed [amd_pkg::SumW-1:0] sum_q, sum_d;
  logic signed [amd_pkg::ValW-1:0] val2_q;

  logic [amd_pkg::SumW-1:0] sum_mag;
  logic [MeanProdW-1:0] mean_prod;
  logic [amd_pkg::ValW-1:0] mean_mag_q;
  logic mean_neg_q;
  logic signed [amd_pkg::ValW-1:0] val3_q;

  logic signed [17:0] mean_s, diff;
  logic [17:0] diff_abs;
  logic signed [amd_pkg::ValW-1:0] val4_q;
  logic mot_q;

  assign frac_mag  = frac_i[amd_pkg::FracW-1] ? amd_pkg::FracW'(-frac_i) : frac_i;
  assign frac_prod = FracProdW'(frac_mag) * FracProdW'(amd_pkg::FracRecip);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en1) begin
      frac_neg_q <= frac_i[amd_pkg::FracW-1];
      quot_q     <= frac_prod[amd_pkg::FracShift +: amd_pkg::FracQuotW];
      wh_q       <= 17'(whole_i) * 17'sd100;
    end
  end

  always_comb begin
    quot_s  = frac_neg_q ? -$signed({9'b0, quot_q}) : $signed({9'b0, quot_q});
    val_sum = wh_q + quot_s;
    value   = val_sum[amd_pkg::ValW-1:0];
    sum_d   = sum_q - amd_pkg::SumW'(hist_q[ctl_i.slot]) + amd_pkg::SumW'(value);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < amd_pkg::WindowLen; i++) hist_q[i] <= '0;
      sum_q <= '0;
    end else if (ctl_i.upd) begin
      hist_q[ctl_i.slot] <= value;
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en2) val2_q <= value;
  end

  assign sum_mag   = sum_q[amd_pkg::SumW-1] ? amd_pkg::SumW'(-sum_q) : sum_q;
  assign mean_prod = MeanProdW'(sum_mag) * MeanProdW'(amd_pkg::MeanRecip);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en3) begin
      mean_neg_q <= sum_q[amd_pkg::SumW-1];
      mean_mag_q <= mean_prod[amd_pkg::MeanShift +: amd_pkg::ValW];
      val3_q     <= val2_q;
    end
  end

  always_comb begin
    mean_s   = mean_neg_q ? -$signed({2'b0, mean_mag_q}) : $signed({2'b0, mean_mag_q});
    diff     = 18'(val3_q) - mean_s;
    diff_abs = diff[17] ? 18'(-diff) : diff;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en4) begin
      val4_q <= val3_q;
      mot_q  <= diff_abs > 18'(thresh_i);
    end
  end

  assign value_o  = val4_q;
  assign motion_o = mot_q;

  `AMD_ASSERT_IMP(sum_holds, clk_i, rst_ni, !ctl_i.upd, ##1 $stable(sum_q))
  `AMD_ASSERT_IMP(upd_needs_move, clk_i, rst_ni, ctl_i.upd, ctl_i.en2)

endmodule

### rtl/accel_motion_detector_core.sv
// Top level of the three-axis motion detector: one lane per axis and the result merge.
// Depends on amd_pkg, amd_ctrl and amd_lane.
//
// Channel  | Dir | Bits | Contents
// s_axis   | in  | 96   | one accelerometer sample, three axes
// m_axis   | out | 56   | converted values and motion flags
// cfg      | in  | 16   | motion threshold, written with cfg_we_i
//
// Each sample passes through the pipeline from transfer in to result out; one
// sample can enter every cycle unless the output stalls. The rate is set by the
// running sum in each lane, which is updated once per sample. Reset clears the
// histories, the sums, the write slot and the threshold (to 250). A stalled
// output fills the four pipeline stages before the input stops taking samples.
module accel_motion_detector_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // x_whole, x_frac, y_whole, y_frac, z_whole, z_frac, zero pad
  input  logic [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // x_value, y_value, z_value, x_motion, y_motion, z_motion, zero pad
  output logic [55:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [amd_pkg::ThrW-1:0] cfg_wdata_i
);

  amd_pkg::pipe_ctl_t ctl;
  logic [amd_pkg::ThrW-1:0] thr_q;
  logic signed [amd_pkg::ValW-1:0] val [3];
  logic [2:0] mot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= amd_pkg::ThresholdReset;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  amd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .ctl_o       (ctl)
  );

  for (genvar a = 0; a < 3; a++) begin : g_lane
    amd_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl),
      .whole_i  (s_axis_tdata[a*31 +: amd_pkg::WholeW]),
      .frac_i   (s_axis_tdata[a*31 + amd_pkg::WholeW +: amd_pkg::FracW]),
      .thresh_i (thr_q),
      .value_o  (val[a]),
      .motion_o (mot[a])
    );
  end

  assign m_axis_tdata = {5'b0, mot, val[2], val[1], val[0]};

endmodule
